@@ rtl/core/text_stream_similarity_compare_defines.svh @@
// Assertion macros for the checker file of the stream compare block.
`ifndef TEXT_STREAM_SIMILARITY_COMPARE_DEFINES_SVH
`define TEXT_STREAM_SIMILARITY_COMPARE_DEFINES_SVH

// Property checked at every edge, reset included.
`define TSSC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error("tssc: assertion failed");

// Property checked only while out of reset.
`define TSSC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("tssc: assertion failed");

`endif

@@ rtl/core/tssc_pkg.sv @@
// Shared types, codes and helper functions of the stream compare block.
package tssc_pkg;

    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int VERDICT_W = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;
    localparam int CMD_DEPTH = 4;

    localparam logic [OP_W-1:0] OP_BYTE_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_BYTE_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_END_FIRST   = 2'd2;
    localparam logic [OP_W-1:0] OP_END_SECOND  = 2'd3;

    localparam logic [VERDICT_W-1:0] VERDICT_IDENTICAL = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_DIFFERENT = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_SIMILAR   = 2'd2;

    typedef enum logic [1:0] {
        CMD_BYTE_FIRST,
        CMD_BYTE_SECOND,
        CMD_PAIR_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [BYTE_W-1:0] data;
        logic              blank;
    } cmd_t;

    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
    endfunction

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        if ((c >= 8'd97) && (c <= 8'd122)) begin
            return c - 8'd32;
        end
        return c;
    endfunction

endpackage

@@ rtl/core/tssc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/tssc_front.sv @@
// Front end: accepts input words, drops late bytes and end marks, classifies.
module tssc_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // operation [1:0], data_byte [9:2], zero [15:10]
    input  logic [tssc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             cmd_full,
    output logic                             cmd_push,
    output tssc_pkg::cmd_t                   cmd
);

    logic                          first_ended_reg, first_ended_next;
    logic                          second_ended_reg, second_ended_next;
    logic                          accept;
    logic [tssc_pkg::OP_W-1:0]     op;
    logic [tssc_pkg::BYTE_W-1:0]   data_byte;

    assign s_tready  = !cmd_full;
    assign accept    = s_tvalid && !cmd_full;
    assign op        = s_tdata[1:0];
    assign data_byte = s_tdata[9:2];

    always_comb begin
        first_ended_next  = first_ended_reg;
        second_ended_next = second_ended_reg;
        cmd_push          = 1'b0;
        cmd.kind          = tssc_pkg::CMD_BYTE_FIRST;
        cmd.data          = data_byte;
        cmd.blank         = tssc_pkg::is_blank(data_byte);
        if (accept) begin
            unique case (op)
                tssc_pkg::OP_BYTE_FIRST: begin
                    cmd_push = !first_ended_reg;
                    cmd.kind = tssc_pkg::CMD_BYTE_FIRST;
                end
                tssc_pkg::OP_BYTE_SECOND: begin
                    cmd_push = !second_ended_reg;
                    cmd.kind = tssc_pkg::CMD_BYTE_SECOND;
                end
                tssc_pkg::OP_END_FIRST: begin
                    if (!first_ended_reg) begin
                        if (second_ended_reg) begin
                            // both ended: close the pair and start fresh
                            cmd_push          = 1'b1;
                            cmd.kind          = tssc_pkg::CMD_PAIR_END;
                            second_ended_next = 1'b0;
                        end else begin
                            first_ended_next = 1'b1;
                        end
                    end
                end
                tssc_pkg::OP_END_SECOND: begin
                    if (!second_ended_reg) begin
                        if (first_ended_reg) begin
                            cmd_push         = 1'b1;
                            cmd.kind         = tssc_pkg::CMD_PAIR_END;
                            first_ended_next = 1'b0;
                        end else begin
                            second_ended_next = 1'b1;
                        end
                    end
                end
                default: begin
                    cmd_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_ended_reg  <= 1'b0;
            second_ended_reg <= 1'b0;
        end else begin
            first_ended_reg  <= first_ended_next;
            second_ended_reg <= second_ended_next;
        end
    end

endmodule

@@ rtl/core/tssc_cmd_fifo.sv @@
// Short command queue between front end and back end.
module tssc_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tssc_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output tssc_pkg::cmd_t head_cmd
);

    localparam int PTR_W = $clog2(tssc_pkg::CMD_DEPTH);
    localparam int CNT_W = $clog2(tssc_pkg::CMD_DEPTH + 1);

    tssc_pkg::cmd_t   mem_reg [tssc_pkg::CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(tssc_pkg::CMD_DEPTH));
    assign valid    = (count_reg != '0);
    assign head_cmd = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(tssc_pkg::CMD_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(tssc_pkg::CMD_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/core/tssc_back.sv @@
// Back end: lead queues for the exact and similarity checks, verdict register.
module tssc_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cmd_valid,
    input  tssc_pkg::cmd_t                 cmd,
    output logic                           cmd_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // verdict [1:0], overflow [2], zero [7:3]
    output logic [tssc_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int NUM_CHECKS = 2;

    // per check: index 0 exact, index 1 similarity
    logic [PTR_W-1:0]            head_reg      [NUM_CHECKS];
    logic [PTR_W-1:0]            head_next     [NUM_CHECKS];
    logic [CNT_W-1:0]            count_reg     [NUM_CHECKS];
    logic [CNT_W-1:0]            count_next    [NUM_CHECKS];
    logic [NUM_CHECKS-1:0]       lead_reg, lead_next;
    logic [NUM_CHECKS-1:0]       ok_reg, ok_next;
    logic [NUM_CHECKS-1:0]       cmp_valid_reg, cmp_valid_next;
    logic [tssc_pkg::BYTE_W-1:0] cmp_byte_reg  [NUM_CHECKS];
    logic [tssc_pkg::BYTE_W-1:0] cmp_byte_next [NUM_CHECKS];
    logic [tssc_pkg::BYTE_W-1:0] rd_data       [NUM_CHECKS];
    logic [PTR_W-1:0]            tail          [NUM_CHECKS];
    logic [NUM_CHECKS-1:0]       ram_we, ram_re;
    logic [NUM_CHECKS-1:0]       ok_eff, count_zero, over_hit;

    logic                             overran_reg, overran_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [tssc_pkg::M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                             out_free, is_end, pair_done, fire, side;
    logic [tssc_pkg::VERDICT_W-1:0]   verdict;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign is_end    = (cmd.kind == tssc_pkg::CMD_PAIR_END);
    assign fire      = cmd_valid && (!is_end || out_free);
    assign pair_done = fire && is_end;
    assign side      = (cmd.kind == tssc_pkg::CMD_BYTE_SECOND);
    assign cmd_pop   = fire;

    for (genvar c = 0; c < NUM_CHECKS; c++) begin : g_check
        localparam bit FOLD = (c == 1);

        logic                        lane_en, act, is_push, q_full, mism;
        logic [CNT_W:0]              tail_sum;
        logic [tssc_pkg::BYTE_W-1:0] rd_cmp, byte_cmp;

        tssc_ram #(
            .WIDTH (tssc_pkg::BYTE_W),
            .DEPTH (QUEUE_DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (ram_we[c]),
            .waddr (tail[c]),
            .wdata (cmd.data),
            .re    (ram_re[c]),
            .raddr (head_reg[c]),
            .rdata (rd_data[c])
        );

        always_comb begin
            rd_cmp   = FOLD ? tssc_pkg::fold_case(rd_data[c]) : rd_data[c];
            byte_cmp = FOLD ? tssc_pkg::fold_case(cmp_byte_reg[c]) : cmp_byte_reg[c];
            mism     = (rd_cmp != byte_cmp);
            // fold in a mismatch from the compare still in flight
            ok_eff[c]     = ok_reg[c] && !(cmp_valid_reg[c] && mism);
            count_zero[c] = (count_reg[c] == '0);
            lane_en  = !is_end && (!FOLD || !cmd.blank);
            act      = fire && lane_en && ok_eff[c];
            is_push  = count_zero[c] || (lead_reg[c] == side);
            q_full   = (count_reg[c] == CNT_W'(QUEUE_DEPTH));
            tail_sum = {1'b0, {(CNT_W - PTR_W){1'b0}}, head_reg[c]} +
                       {1'b0, count_reg[c]};
            tail[c]  = (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) ?
                       PTR_W'(tail_sum - (CNT_W + 1)'(QUEUE_DEPTH)) :
                       PTR_W'(tail_sum);

            head_next[c]     = head_reg[c];
            count_next[c]    = count_reg[c];
            lead_next[c]     = lead_reg[c];
            ok_next[c]       = ok_eff[c];
            cmp_valid_next[c] = 1'b0;
            cmp_byte_next[c] = cmp_byte_reg[c];
            ram_we[c]        = 1'b0;
            ram_re[c]        = 1'b0;
            over_hit[c]      = 1'b0;

            if (act) begin
                if (is_push) begin
                    if (q_full) begin
                        // drop the word and flag the overrun
                        over_hit[c] = 1'b1;
                    end else begin
                        ram_we[c]     = 1'b1;
                        count_next[c] = count_reg[c] + CNT_W'(1);
                        lead_next[c]  = side;
                    end
                end else begin
                    ram_re[c]         = 1'b1;
                    head_next[c]      = (head_reg[c] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                        '0 : head_reg[c] + PTR_W'(1);
                    count_next[c]     = count_reg[c] - CNT_W'(1);
                    cmp_valid_next[c] = 1'b1;
                    cmp_byte_next[c]  = cmd.data;
                end
            end

            if (pair_done) begin
                head_next[c]  = '0;
                count_next[c] = '0;
                lead_next[c]  = 1'b0;
                ok_next[c]    = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                head_reg[c]      <= '0;
                count_reg[c]     <= '0;
                lead_reg[c]      <= 1'b0;
                ok_reg[c]        <= 1'b1;
                cmp_valid_reg[c] <= 1'b0;
            end else begin
                head_reg[c]      <= head_next[c];
                count_reg[c]     <= count_next[c];
                lead_reg[c]      <= lead_next[c];
                ok_reg[c]        <= ok_next[c];
                cmp_valid_reg[c] <= cmp_valid_next[c];
            end
        end

        always_ff @(posedge aclk) begin
            cmp_byte_reg[c] <= cmp_byte_next[c];
        end
    end

    always_comb begin
        if (ok_eff[0] && count_zero[0]) begin
            verdict = tssc_pkg::VERDICT_IDENTICAL;
        end else if (ok_eff[1] && count_zero[1]) begin
            verdict = tssc_pkg::VERDICT_SIMILAR;
        end else begin
            verdict = tssc_pkg::VERDICT_DIFFERENT;
        end

        overran_next  = pair_done ? 1'b0 : (overran_reg || (|over_hit));
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (pair_done) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{(tssc_pkg::M_TDATA_W - tssc_pkg::VERDICT_W - 1){1'b0}},
                             overran_reg, verdict};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overran_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            overran_reg  <= overran_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ rtl/core/text_stream_similarity_compare.sv @@
// Path: a pair's closing end mark passes the command queue register and then the verdict
// register before its verdict word appears, if the queues are not backed up; a mismatch
// from the last lead-queue read is folded into the verdict in the same cycle.
// Throughput: one input word per cycle, sustained, as long as the result side drains.
// Reset: aresetn is synchronous, active low; it clears all control state. The lead-queue
// RAMs are not cleared: an entry is read only after it was written.
module text_stream_similarity_compare #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // operation [1:0], data_byte [9:2], zero [15:10]
    input  logic [tssc_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // verdict [1:0], overflow [2], zero [7:3]
    output logic [tssc_pkg::M_TDATA_W-1:0] m_tdata
);

    tssc_pkg::cmd_t front_cmd, head_cmd;
    logic           front_push, fifo_full, fifo_valid, fifo_pop;

    tssc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cmd_full (fifo_full),
        .cmd_push (front_push),
        .cmd      (front_cmd)
    );

    tssc_cmd_fifo u_cmd_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (front_push),
        .push_cmd (front_cmd),
        .full     (fifo_full),
        .pop      (fifo_pop),
        .valid    (fifo_valid),
        .head_cmd (head_cmd)
    );

    tssc_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (fifo_valid),
        .cmd       (head_cmd),
        .cmd_pop   (fifo_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ rtl/core/tssc_checker.sv @@
// Port-level checker for the stream compare block, bound to the top level.
`include "text_stream_similarity_compare_defines.svh"

module tssc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [tssc_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tssc_pkg::M_TDATA_W-1:0] m_tdata
);

    logic result_legal;
    assign result_legal = ((m_tdata[1:0] == tssc_pkg::VERDICT_IDENTICAL) ||
                           (m_tdata[1:0] == tssc_pkg::VERDICT_DIFFERENT) ||
                           (m_tdata[1:0] == tssc_pkg::VERDICT_SIMILAR)) &&
                          (m_tdata[7:3] == 5'd0);

    // no verdict word right after reset
    `TSSC_ASSERT_ALWAYS(a_no_result_after_reset, !aresetn |=> !m_tvalid)

    // input side open right after reset: command queue starts empty
    `TSSC_ASSERT_ALWAYS(a_ready_after_reset, !aresetn |=> s_tready)

    // stalled verdict word holds
    `TSSC_ASSERT(a_result_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

    // verdict code legal and padding zero
    `TSSC_ASSERT(a_result_legal, m_tvalid |-> result_legal)

    // padding above the data byte stays zero on every offered word
    `TSSC_ASSERT(a_input_pad, s_tvalid |-> (s_tdata[15:10] == 6'd0))

endmodule

bind text_stream_similarity_compare tssc_checker u_tssc_checker (.*);
